FILE: sv/oaht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package oaht_pkg;
  localparam int MAX_SLOTS_D  = 37;
  localparam int KEY_BITS_D   = 32;
  localparam int VALUE_BITS_D = 32;
  localparam int LAST_LEVEL   = 3;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_REBUILT   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_FIND   = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] key;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  slot;
    logic [31:0] value_out;
    logic [5:0]  probe_count;
    logic [1:0]  size_level;
  } rsp_t;

  // Table size for a level, clamped to the number of physical slots.
  function automatic logic [5:0] level_size(input logic [1:0] lvl, input int max_slots);
    logic [5:0] s;
    begin
      unique case (lvl)
        2'd0: s = 6'd11;
        2'd1: s = 6'd19;
        2'd2: s = 6'd29;
        default: s = 6'd37;
      endcase
      if (int'(s) > max_slots) s = 6'(max_slots);
      return s;
    end
  endfunction
endpackage
`default_nettype wire

FILE: sv/oaht_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module oaht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 37
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire  [$clog2(DEPTH)-1:0]  waddr,
  input  wire  [WIDTH-1:0]          wdata,
  input  wire  [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]          rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/oaht_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Input queue of two entries: it takes a new request while the engine is busy.
module oaht_front (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  oaht_pkg::req_t       in_data,
  output logic                 q_valid,
  input  wire                  q_take,
  output oaht_pkg::req_t       q_data
);
  import oaht_pkg::*;

  req_t       buf_r [2];
  logic       rd_r, wr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign pop      = q_take && q_valid;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = buf_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_r <= !wr_r;
      if (pop) rd_r <= !rd_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) buf_r[wr_r] <= in_data;
  end
endmodule
`default_nettype wire

FILE: sv/oaht_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// Probe engine. Key and value memories have one registered read port, so each probe
// step issues a read and compares in the following cycle. Rebuild copies valid
// entries to the rebuild buffer, grows the table and reinserts them one by one.
module oaht_engine #(
  parameter int MAX_SLOTS  = oaht_pkg::MAX_SLOTS_D,
  parameter int KEY_BITS   = oaht_pkg::KEY_BITS_D,
  parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_D
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             q_valid,
  output logic            q_take,
  input  oaht_pkg::req_t  q_data,
  output logic            out_valid,
  input  wire             out_stall,
  output oaht_pkg::rsp_t  out_data
);
  import oaht_pkg::*;

  localparam int AW = $clog2(MAX_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE, S_HOME, S_HDIV, S_HREM, S_READ, S_CMP, S_DONE,
    S_G_RD, S_G_WAIT, S_G_CPY, S_RB_START, S_RB_RD, S_RB_LOAD, S_MV_RD, S_MV_WR
  } state_t;

  state_t               state_r;
  logic [MAX_SLOTS-1:0] used_r;
  logic [1:0]           level_r;
  logic                 is_find_r, in_rb_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [5:0]           pos_r, cnt_r, size_r;
  logic [5:0]           gi_r, gk_r, n_r, ri_r, mv_r, rest_r;
  rsp_t                 rsp_r;
  logic                 out_valid_r;

  // memory ports
  logic                 sk_we, rk_we;
  logic [AW-1:0]        sk_wa, sk_ra, rk_wa, rk_ra;
  logic [KEY_BITS-1:0]  sk_wd, sk_rd, rk_wd, rk_rd;
  logic [VALUE_BITS-1:0] sv_wd, sv_rd, rv_wd, rv_rd;

  oaht_ram #(.WIDTH(KEY_BITS),   .DEPTH(MAX_SLOTS)) u_sk (.clk(clk), .we(sk_we),
    .waddr(sk_wa), .wdata(sk_wd), .raddr(sk_ra), .rdata(sk_rd));
  oaht_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_SLOTS)) u_sv (.clk(clk), .we(sk_we),
    .waddr(sk_wa), .wdata(sv_wd), .raddr(sk_ra), .rdata(sv_rd));
  oaht_ram #(.WIDTH(KEY_BITS),   .DEPTH(MAX_SLOTS)) u_rk (.clk(clk), .we(rk_we),
    .waddr(rk_wa), .wdata(rk_wd), .raddr(rk_ra), .rdata(rk_rd));
  oaht_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_SLOTS)) u_rv (.clk(clk), .we(rk_we),
    .waddr(rk_wa), .wdata(rv_wd), .raddr(rk_ra), .rdata(rv_rd));

  logic [AW-1:0] pos_a;
  logic          hit, slot_free;
  logic [6:0]    step;
  logic [5:0]    half;
  logic [5:0]    cnt_inc;
  assign pos_a     = pos_r[AW-1:0];
  assign slot_free = !used_r[pos_a];
  assign hit       = used_r[pos_a] && (sk_rd == key_r);
  assign cnt_inc   = cnt_r + 6'd1;
  assign step      = 7'(pos_r) + 7'(cnt_inc);
  assign half      = size_r >> 1;

  // Home slot in the states S_HOME, S_HDIV and S_HREM. The key is split as hi * 2^16 + lo, so
  // its remainder equals that of hi * (2^16 mod size) + lo, a value below 2^22. That sum is
  // divided by a rounded-up reciprocal of the size, which is exact over this range.
  localparam int FOLD_SH = 28;
  localparam int SZ0 = int'(level_size(2'd0, MAX_SLOTS));
  localparam int SZ1 = int'(level_size(2'd1, MAX_SLOTS));
  localparam int SZ2 = int'(level_size(2'd2, MAX_SLOTS));
  localparam int SZ3 = int'(level_size(2'd3, MAX_SLOTS));
  localparam logic [5:0]  W0 = 6'(65536 % SZ0);
  localparam logic [5:0]  W1 = 6'(65536 % SZ1);
  localparam logic [5:0]  W2 = 6'(65536 % SZ2);
  localparam logic [5:0]  W3 = 6'(65536 % SZ3);
  localparam logic [24:0] R0 = 25'(((1 << FOLD_SH) + SZ0 - 1) / SZ0);
  localparam logic [24:0] R1 = 25'(((1 << FOLD_SH) + SZ1 - 1) / SZ1);
  localparam logic [24:0] R2 = 25'(((1 << FOLD_SH) + SZ2 - 1) / SZ2);
  localparam logic [24:0] R3 = 25'(((1 << FOLD_SH) + SZ3 - 1) / SZ3);

  logic [31:0] key32;
  logic [5:0]  fold_w;
  logic [24:0] recip;
  logic [21:0] fold_sum, fold_r, home_rem;
  logic [46:0] prod;
  logic [18:0] quo_r;
  logic [24:0] qmul;

  always_comb begin
    unique case (level_r)
      2'd0: begin fold_w = W0; recip = R0; end
      2'd1: begin fold_w = W1; recip = R1; end
      2'd2: begin fold_w = W2; recip = R2; end
      default: begin fold_w = W3; recip = R3; end
    endcase
  end

  assign key32    = 32'(key_r);
  assign fold_sum = {6'd0, key32[31:16]} * {16'd0, fold_w} + {6'd0, key32[15:0]};
  assign prod     = {25'd0, fold_r} * {22'd0, recip};
  assign qmul     = {6'd0, quo_r} * {19'd0, size_r};
  assign home_rem = fold_r - qmul[21:0];

  assign q_take    = (state_r == S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = rsp_r;

  always_comb begin
    sk_we = 1'b0; sk_wa = pos_a; sk_wd = key_r; sv_wd = val_r;
    sk_ra = pos_a;
    rk_we = 1'b0; rk_wa = gk_r[AW-1:0]; rk_wd = sk_rd; rv_wd = sv_rd;
    rk_ra = ri_r[AW-1:0];
    unique case (state_r)
      S_CMP: begin
        if (!hit && (slot_free || cnt_inc >= size_r) && !is_find_r && cnt_r < half
            && slot_free)
          sk_we = 1'b1;
      end
      S_G_RD: sk_ra = gi_r[AW-1:0];
      S_G_WAIT: sk_ra = gi_r[AW-1:0];
      S_G_CPY: rk_we = 1'b1;
      S_MV_RD: rk_ra = mv_r[AW-1:0];
      S_MV_WR: begin
        rk_we = 1'b1; rk_wa = gk_r[AW-1:0]; rk_wd = rk_rd; rv_wd = rv_rd;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      level_r     <= 2'd0;
      out_valid_r <= 1'b0;
      in_rb_r     <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid && q_take) begin
            is_find_r <= (q_data.req_type == REQ_FIND);
            key_r     <= KEY_BITS'(q_data.key);
            val_r     <= VALUE_BITS'(q_data.value);
            size_r    <= level_size(level_r, MAX_SLOTS);
            pos_r     <= 6'd0;
            cnt_r     <= 6'd0;
            in_rb_r   <= 1'b0;
            state_r   <= S_HOME;
          end
        end
        S_HOME: begin
          fold_r  <= fold_sum;
          state_r <= S_HDIV;
        end
        S_HDIV: begin
          quo_r   <= prod[46:28];
          state_r <= S_HREM;
        end
        S_HREM: begin
          pos_r   <= home_rem[5:0];
          state_r <= S_READ;
        end
        S_READ: state_r <= S_CMP;
        S_CMP: begin
          if (!hit && used_r[pos_a] && cnt_inc < size_r) begin
            cnt_r   <= cnt_inc;
            pos_r   <= (step >= 7'(size_r)) ? 6'(step - 7'(size_r)) : step[5:0];
            state_r <= S_READ;
          end else begin
            if (!hit && used_r[pos_a]) cnt_r <= cnt_inc;
            if (in_rb_r) begin
              // reinsertion of a buffered entry
              if (hit) begin
                ri_r <= ri_r + 6'd1; state_r <= S_RB_START;
              end else if (slot_free && cnt_r < half) begin
                used_r[pos_a] <= 1'b1;
                ri_r <= ri_r + 6'd1; state_r <= S_RB_START;
              end else if (level_r == 2'(LAST_LEVEL)) begin
                ri_r <= ri_r + 6'd1; state_r <= S_RB_START;
              end else begin
                // nested rebuild: regather, then append the waiting entries
                rest_r  <= n_r - ri_r - 6'd1;
                mv_r    <= ri_r + 6'd1;
                gi_r    <= 6'd0; gk_r <= 6'd0;
                state_r <= S_G_RD;
              end
            end else begin
              rsp_r.slot        <= pos_r;
              rsp_r.probe_count <= (!hit && used_r[pos_a]) ? cnt_inc : cnt_r;
              rsp_r.value_out   <= '0;
              rsp_r.size_level  <= level_r;
              if (is_find_r) begin
                rsp_r.status <= hit ? ST_FOUND : ST_NOT_FOUND;
                if (hit) rsp_r.value_out <= 32'(sv_rd);
                state_r <= S_DONE;
              end else if (hit) begin
                rsp_r.status <= ST_DUPLICATE; state_r <= S_DONE;
              end else if (slot_free && cnt_r < half) begin
                used_r[pos_a] <= 1'b1;
                rsp_r.status <= ST_INSERTED; state_r <= S_DONE;
              end else if (level_r == 2'(LAST_LEVEL)) begin
                rsp_r.status <= ST_FULL; state_r <= S_DONE;
              end else begin
                rsp_r.status <= ST_REBUILT;
                rest_r <= 6'd0; mv_r <= 6'd0;
                gi_r <= 6'd0; gk_r <= 6'd0;
                state_r <= S_G_RD;
              end
            end
          end
        end
        S_G_RD: state_r <= S_G_WAIT;
        S_G_WAIT: state_r <= S_G_CPY;
        S_G_CPY: begin
          if (used_r[gi_r[AW-1:0]]) gk_r <= gk_r + 6'd1;
          if (gi_r == 6'(MAX_SLOTS - 1)) begin
            state_r <= (rest_r != 6'd0) ? S_MV_RD : S_RB_START;
            n_r     <= (used_r[gi_r[AW-1:0]] ? gk_r + 6'd1 : gk_r) + rest_r;
            level_r <= level_r + 2'd1;
            used_r  <= '0;
            ri_r    <= 6'd0;
            in_rb_r <= 1'b1;
          end else begin
            gi_r <= gi_r + 6'd1; state_r <= S_G_RD;
          end
        end
        // Move waiting entries down: read at mv, write at gk (gk never exceeds mv).
        S_MV_RD: state_r <= S_MV_WR;
        S_MV_WR: begin
          gk_r <= gk_r + 6'd1; mv_r <= mv_r + 6'd1; rest_r <= rest_r - 6'd1;
          state_r <= (rest_r == 6'd1) ? S_RB_START : S_MV_RD;
        end
        S_RB_START: begin
          if (ri_r >= n_r) begin
            in_rb_r <= 1'b0;
            rsp_r.size_level <= level_r;
            state_r <= S_DONE;
          end else state_r <= S_RB_LOAD;
        end
        S_RB_LOAD: state_r <= S_RB_RD;
        S_RB_RD: begin
          key_r  <= rk_rd; val_r <= rv_rd;
          size_r <= level_size(level_r, MAX_SLOTS);
          pos_r  <= 6'd0; cnt_r <= 6'd0;
          state_r <= S_HOME;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1; state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/open_addressing_hash_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Open-addressing hash table of 11, 19, 29 or 37 slots that grows by rebuilding.
// A request is taken from the queue, its home slot is formed (a fold of the key and a
// reciprocal multiply), each probe reads the slot memories, which have one registered
// read port, and then compares, and the result is presented. A rebuild gathers every
// slot, moves the waiting entries down after a nested rebuild, and forms the home slot
// and probes anew for each reinserted entry. A two-entry input queue accepts requests while
// the engine works; the engine takes no new request until the result register has
// handed over its transfer.
module open_addressing_hash_table #(
  parameter int MAX_SLOTS  = oaht_pkg::MAX_SLOTS_D,
  parameter int KEY_BITS   = oaht_pkg::KEY_BITS_D,
  parameter int VALUE_BITS = oaht_pkg::VALUE_BITS_D
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  oaht_pkg::req_t  in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output oaht_pkg::rsp_t  out_data
);
  import oaht_pkg::*;

  logic q_valid, q_take;
  req_t q_data;

  oaht_front u_front (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_valid(q_valid), .q_take(q_take), .q_data(q_data));

  oaht_engine #(.MAX_SLOTS(MAX_SLOTS), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS))
    u_engine (.clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
    .q_data(q_data), .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data));

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_FULL) else $error("bad status");
  a_found_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_FOUND |-> out_data.value_out == '0)
    else $error("value on miss");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("output dropped");
endmodule
`default_nettype wire

FILE: tb/tb_open_addressing_hash_table.sv
`timescale 1ns / 1ps
module tb_open_addressing_hash_table;
  import oaht_pkg::*;

  localparam int NUM_RANDOM  = 1400;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  open_addressing_hash_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the table.
  logic [31:0] tbl_keys [37];
  logic [31:0] tbl_vals [37];
  logic        tbl_used [37];
  logic [1:0]  tbl_level;
  logic [31:0] regrow_keys [74];
  logic [31:0] regrow_vals [74];

  rsp_t pending_rsp[$];
  logic has_fixed[$];
  rsp_t fixed_rsp[$];
  int mismatches;
  int results_seen;
  int status_hits [6];
  int cycles;
  int rebuild_total;

  function automatic int table_size(input logic [1:0] lvl);
    case (lvl)
      2'd0: return 11;
      2'd1: return 19;
      2'd2: return 29;
      default: return 37;
    endcase
  endfunction

  function automatic bit lookup(input logic [31:0] key, output int pos, output int cnt);
    int sz;
    sz = table_size(tbl_level);
    pos = key % sz;
    cnt = 0;
    while (tbl_used[pos] && tbl_keys[pos] != key) begin
      cnt++;
      if (cnt < sz) pos = (pos + cnt) % sz;
      else break;
    end
    return tbl_used[pos] && tbl_keys[pos] == key;
  endfunction

  // 0 duplicate, 1 stored, 2 table too crowded.
  function automatic int place(input logic [31:0] key, input logic [31:0] val,
                               output int pos, output int cnt);
    if (lookup(key, pos, cnt)) return 0;
    if (cnt < table_size(tbl_level) / 2) begin
      tbl_keys[pos] = key;
      tbl_vals[pos] = val;
      tbl_used[pos] = 1'b1;
      return 1;
    end
    return 2;
  endfunction

  function automatic int collect();
    int k;
    k = 0;
    for (int i = 0; i < 37; i++) begin
      if (tbl_used[i]) begin
        regrow_keys[k] = tbl_keys[i];
        regrow_vals[k] = tbl_vals[i];
        k++;
      end
    end
    return k;
  endfunction

  function automatic void clear_used();
    for (int i = 0; i < 37; i++) tbl_used[i] = 1'b0;
  endfunction

  function automatic void grow(input int n);
    int i, p, c, rest, k;
    logic [31:0] tk [74];
    logic [31:0] tv [74];
    i = 0;
    tbl_level++;
    clear_used();
    while (i < n) begin
      if (place(regrow_keys[i], regrow_vals[i], p, c) != 2) begin
        i++;
      end else if (tbl_level >= 2'(LAST_LEVEL)) begin
        i++;
      end else begin
        // A reinserted entry failed: grow again with what is stored so far first.
        rest = n - i - 1;
        for (int j = 0; j < rest; j++) begin
          tk[j] = regrow_keys[i + 1 + j];
          tv[j] = regrow_vals[i + 1 + j];
        end
        k = collect();
        for (int j = 0; j < rest; j++) begin
          regrow_keys[k + j] = tk[j];
          regrow_vals[k + j] = tv[j];
        end
        n = k + rest;
        tbl_level++;
        clear_used();
        i = 0;
      end
    end
  endfunction

  function automatic rsp_t predict_request(input req_t rq);
    rsp_t r;
    int p, c, res;
    r = '0;
    if (rq.req_type == REQ_FIND) begin
      if (lookup(rq.key, p, c)) begin
        r.status = ST_FOUND;
        r.value_out = tbl_vals[p];
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end else begin
      res = place(rq.key, rq.value, p, c);
      if (res == 0) r.status = ST_DUPLICATE;
      else if (res == 1) r.status = ST_INSERTED;
      else if (tbl_level >= 2'(LAST_LEVEL)) r.status = ST_FULL;
      else begin
        grow(collect());
        r.status = ST_REBUILT;
        rebuild_total++;
      end
    end
    r.slot = 6'(p);
    r.probe_count = 6'(c);
    r.size_level = tbl_level;
    return r;
  endfunction

  // Directed rows; a fixed expectation is given only where it is obvious.
  typedef struct {
    logic        req_type;
    logic [31:0] key;
    logic [31:0] value;
    bit          fixed;
    rsp_t        rsp;
  } row_t;

  row_t rows [$];

  function automatic rsp_t mk(input logic [2:0] st, input int sl, input logic [31:0] v,
                              input int pc, input int lv);
    rsp_t r;
    r.status = st;
    r.slot = 6'(sl);
    r.value_out = v;
    r.probe_count = 6'(pc);
    r.size_level = 2'(lv);
    return r;
  endfunction

  function automatic void add_row(input logic t, input logic [31:0] k, input logic [31:0] v,
                                  input bit f, input rsp_t r);
    row_t w;
    w.req_type = t;
    w.key = k;
    w.value = v;
    w.fixed = f;
    w.rsp = r;
    rows.push_back(w);
  endfunction

  task automatic send(input req_t rq, input bit fixed, input rsp_t fr);
    int gap;
    if ($urandom_range(0, 3) == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= rq;
    pending_rsp.push_back(predict_request(rq));
    has_fixed.push_back(fixed);
    fixed_rsp.push_back(fr);
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Result side: random stalls, checked at each accepted transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        rsp_t e;
        results_seen++;
        if (out_data.status < 3'd6) status_hits[out_data.status]++;
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", out_data);
        end else begin
          e = pending_rsp.pop_front();
          if (has_fixed.pop_front()) e = fixed_rsp.pop_front();
          else void'(fixed_rsp.pop_front());
          if (out_data.status != e.status || out_data.slot != e.slot ||
              out_data.value_out != e.value_out || out_data.probe_count != e.probe_count ||
              out_data.size_level != e.size_level) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Mismatch: expected %p, got %p", e, out_data);
          end
        end
      end
      if ($urandom_range(0, 99) < 70) out_stall <= 1'b0;
      else if ($urandom_range(0, 19) == 0) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(0, 2) == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("FAIL open_addressing_hash_table");
      $finish;
    end
  end

  initial begin
    req_t rq;
    int tail;
    logic [31:0] base;
    logic [31:0] keyring [$];
    mismatches = 0;
    results_seen = 0;
    cycles = 0;
    rebuild_total = 0;
    for (int i = 0; i < 6; i++) status_hits[i] = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    clear_used();
    tbl_level = 2'd0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_row(REQ_FIND, 32'd0, 32'd0, 1, mk(ST_NOT_FOUND, 0, 0, 0, 0));
    add_row(REQ_FIND, 32'hFFFF_FFFF, 32'd0, 1, mk(ST_NOT_FOUND, 32'hFFFF_FFFF % 11, 0, 0, 0));
    add_row(REQ_INSERT, 32'd0, 32'hFFFF_FFFF, 1, mk(ST_INSERTED, 0, 0, 0, 0));
    add_row(REQ_INSERT, 32'd0, 32'h1234, 1, mk(ST_DUPLICATE, 0, 0, 0, 0));
    add_row(REQ_FIND, 32'd0, 32'd0, 1, mk(ST_FOUND, 0, 32'hFFFF_FFFF, 0, 0));
    add_row(REQ_INSERT, 32'hFFFF_FFFF, 32'd0, 0, '0);
    add_row(REQ_FIND, 32'hFFFF_FFFF, 32'h5555_5555, 0, '0);
    // Colliding keys on slot 0 push the probe count to the limit and force a rebuild.
    for (int i = 1; i <= 6; i++) add_row(REQ_INSERT, 32'(11 * i), 32'(i), 0, '0);
    add_row(REQ_FIND, 32'd33, 32'd0, 0, '0);
    add_row(REQ_FIND, 32'd66, 32'd0, 0, '0);
    for (int i = 0; i < 8; i++) add_row(REQ_INSERT, 32'(19 * 29 * i + 7), 32'hA5A5_0000 + i, 0, '0);

    foreach (rows[i]) begin
      rq.req_type = rows[i].req_type;
      rq.key = rows[i].key;
      rq.value = rows[i].value;
      send(rq, rows[i].fixed, rows[i].rsp);
    end

    // Random part: clustered keys so probes run long and the table grows,
    // with finds of known keys, wide random keys and occasional full-table phases.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      base = 32'(table_size(tbl_level)) * $urandom_range(0, 40);
      rq.value = $urandom();
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          rq.req_type = REQ_INSERT;
          rq.key = base + $urandom_range(0, 3);
        end
        3, 4: begin
          rq.req_type = REQ_INSERT;
          rq.key = $urandom();
        end
        5, 6: begin
          rq.req_type = REQ_FIND;
          rq.key = (keyring.size() > 0) ? keyring[$urandom_range(0, keyring.size() - 1)]
                                        : $urandom();
        end
        7: begin
          rq.req_type = REQ_FIND;
          rq.key = $urandom();
        end
        default: begin
          rq.req_type = 1'($urandom_range(0, 1));
          rq.key = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 40)
                                        : $urandom_range(0, 80);
        end
      endcase
      if (rq.req_type == REQ_INSERT) keyring.push_back(rq.key);
      if (keyring.size() > 64) void'(keyring.pop_front());
      send(rq, 0, '0);
    end
    in_valid <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk);
    tail = 0;
    while (tail < 400) begin
      @(posedge clk);
      tail++;
    end

    $display("Requests: %0d, results: %0d, rebuilds predicted: %0d, final level %0d",
             rows.size() + NUM_RANDOM, results_seen, rebuild_total, tbl_level);
    $display("Statuses found/absent/inserted/dup/rebuilt/full: %0d %0d %0d %0d %0d %0d",
             status_hits[0], status_hits[1], status_hits[2], status_hits[3],
             status_hits[4], status_hits[5]);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("PASS open_addressing_hash_table");
    end else begin
      $display("Mismatches: %0d", mismatches);
      $display("FAIL open_addressing_hash_table");
    end
    $finish;
  end
endmodule
